/* rtl/rcpm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared types, codes and constants of the readout channel pad mapper.
// ----------------------------------------------------------------------------
package rcpm_pkg;

    // default sizes
    localparam int NUM_BOARDS_DEF     = 12;
    localparam int NUM_CONNECTORS_DEF = 4;
    localparam int NUM_CHANNELS_DEF   = 68;
    localparam int PAD_ROWS_DEF       = 108;
    localparam int PAD_LAYERS_DEF     = 112;

    // mapping geometry
    localparam int UNIT_BLOCK      = 100;  // unit index = block * 100 + column
    localparam int LAYER_BLOCK     = 28;   // layers per block
    localparam int ROW_PITCH       = 9;    // rows per column
    localparam int CHIP_PITCH      = 7;    // layers per chip
    localparam int MIRROR_COL      = 6;    // first mirrored column
    localparam int ROW_LOCAL_MAX   = 8;
    localparam int LAYER_LOCAL_MAX = 6;
    localparam int CHIP_MAX        = 3;

    localparam int UNIT_W     = 9;
    localparam int USER_W     = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic [UNIT_W-1:0] UNIT_NONE    = '1;
    localparam logic [3:0]        LAYER_UNUSED = 4'b1110;

    typedef enum logic [1:0] {
        OP_LOAD_BOARD   = 2'd0,
        OP_LOAD_CHANNEL = 2'd1,
        OP_FORWARD      = 2'd2,
        OP_REVERSE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNUSED    = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_FWD  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // request item, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic [3:0]        entry_row;
        logic signed [3:0] entry_layer;
        logic [6:0]        pad_layer;
        logic [6:0]        pad_row;
        logic [8:0]        unit_index;
        logic [6:0]        channel;
        logic [1:0]        chip;
        logic [1:0]        connector;
        logic [3:0]        board;
    } t_in_data;

    typedef struct packed {
        logic [1:0] pad;
        logic [6:0] out_channel;
        logic [1:0] out_chip;
        logic [1:0] out_connector;
        logic [3:0] out_board;
        logic [8:0] out_unit;
        logic [6:0] out_pad_layer;
        logic [6:0] out_pad_row;
    } t_out_data;

    typedef struct packed {
        logic [3:0] layer;
        logic [3:0] row;
    } t_ch_entry;

    localparam t_ch_entry CH_ENTRY_RESET = '{layer: LAYER_UNUSED, row: 4'd0};

    typedef struct packed {
        logic bt_rd;
        logic bt_wr;
        logic ch_rd;
        logic ch_wr;
    } t_tbl_ctrl;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage
`default_nettype wire

/* rtl/rcpm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [rcpm_pkg::addr_w(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [rcpm_pkg::addr_w(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);
    import rcpm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/rcpm_tables.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcpm_tables
// Board and channel tables. Entries never written read as their reset value.
// ----------------------------------------------------------------------------
module rcpm_tables #(
    parameter int BT_DEPTH = rcpm_pkg::NUM_BOARDS_DEF * rcpm_pkg::NUM_CONNECTORS_DEF,
    parameter int CH_DEPTH = rcpm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire rcpm_pkg::t_tbl_ctrl                   i_ctrl,
    input  wire logic [rcpm_pkg::addr_w(BT_DEPTH)-1:0] i_bt_addr,
    input  wire logic [rcpm_pkg::UNIT_W-1:0]           i_bt_wdata,
    input  wire logic [rcpm_pkg::addr_w(CH_DEPTH)-1:0] i_ch_addr,
    input  wire rcpm_pkg::t_ch_entry                   i_ch_wdata,
    output logic      [rcpm_pkg::UNIT_W-1:0]           o_bt_unit,
    output rcpm_pkg::t_ch_entry                        o_ch_entry
);
    import rcpm_pkg::*;

    logic [BT_DEPTH-1:0] r_bt_vld;
    logic [CH_DEPTH-1:0] r_ch_vld;
    logic                r_bt_hit;
    logic                r_ch_hit;
    logic [UNIT_W-1:0]   bt_q;
    logic [7:0]          ch_q;

    rcpm_ram #(.WIDTH(UNIT_W), .DEPTH(BT_DEPTH)) u_board_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.bt_wr),
        .i_waddr (i_bt_addr),
        .i_wdata (i_bt_wdata),
        .i_re    (i_ctrl.bt_rd),
        .i_raddr (i_bt_addr),
        .o_rdata (bt_q)
    );

    rcpm_ram #(.WIDTH(8), .DEPTH(CH_DEPTH)) u_channel_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.ch_wr),
        .i_waddr (i_ch_addr),
        .i_wdata (i_ch_wdata),
        .i_re    (i_ctrl.ch_rd),
        .i_raddr (i_ch_addr),
        .o_rdata (ch_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt_vld <= '0;
            r_ch_vld <= '0;
        end else begin
            if (i_ctrl.bt_wr) begin
                r_bt_vld[i_bt_addr] <= 1'b1;
            end
            if (i_ctrl.ch_wr) begin
                r_ch_vld[i_ch_addr] <= 1'b1;
            end
        end
    end

    // valid flag travels with the read data
    always_ff @(posedge i_clk) begin
        if (i_ctrl.bt_rd) begin
            r_bt_hit <= r_bt_vld[i_bt_addr];
        end
        if (i_ctrl.ch_rd) begin
            r_ch_hit <= r_ch_vld[i_ch_addr];
        end
    end

    assign o_bt_unit  = r_bt_hit ? bt_q : UNIT_NONE;
    assign o_ch_entry = r_ch_hit ? t_ch_entry'(ch_q) : CH_ENTRY_RESET;

endmodule
`default_nettype wire

/* rtl/readout_channel_pad_mapper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// readout_channel_pad_mapper
// Loads board and channel tables and maps readout addresses to pad
// coordinates (forward) and pad coordinates back to readout addresses.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              tdata  tuser
//  request   in         i_s_tvalid/o_s_tready  48     operation
//  result    out        o_m_tvalid/i_m_tready  40     status
//
//  Loads go straight to done; forward requests pass the read and forward
//  states; the reverse scan walks max(boards*connectors, channels) entries
//  of both table RAMs side by side, one entry per cycle through their
//  single read ports. One request is in flight at a time; the result
//  register lets the next request in while a result waits on a stalled
//  output. Reset clears per-entry valid flags at once, no clearing pass.
// ----------------------------------------------------------------------------
module readout_channel_pad_mapper #(
    parameter int NUM_BOARDS     = rcpm_pkg::NUM_BOARDS_DEF,
    parameter int NUM_CONNECTORS = rcpm_pkg::NUM_CONNECTORS_DEF,
    parameter int NUM_CHANNELS   = rcpm_pkg::NUM_CHANNELS_DEF,
    parameter int PAD_ROWS       = rcpm_pkg::PAD_ROWS_DEF,
    parameter int PAD_LAYERS     = rcpm_pkg::PAD_LAYERS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // board[3:0] connector[5:4] chip[7:6] channel[14:8] unit_index[23:15]
    // pad_row[30:24] pad_layer[37:31] entry_layer[41:38] entry_row[45:42]
    input  wire logic [rcpm_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // operation[1:0]
    input  wire logic [rcpm_pkg::USER_W-1:0]        i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // out_pad_row[6:0] out_pad_layer[13:7] out_unit[22:14] out_board[26:23]
    // out_connector[28:27] out_chip[30:29] out_channel[37:31]
    output logic      [rcpm_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // status[1:0]
    output logic      [rcpm_pkg::USER_W-1:0]        o_m_tuser
);
    import rcpm_pkg::*;

    localparam int BT_DEPTH = NUM_BOARDS * NUM_CONNECTORS;
    localparam int BT_AW    = addr_w(BT_DEPTH);
    localparam int CH_AW    = addr_w(NUM_CHANNELS);
    localparam int SCAN_LEN = (BT_DEPTH > NUM_CHANNELS) ? BT_DEPTH : NUM_CHANNELS;
    localparam int SC_W     = $clog2(SCAN_LEN + 1);

    localparam logic signed [11:0] ROW_PITCH_S   = 12'(ROW_PITCH);
    localparam logic signed [11:0] ROW_MAX_S     = 12'(ROW_LOCAL_MAX);
    localparam logic signed [9:0]  LAYER_BLK_S   = 10'(LAYER_BLOCK);
    localparam logic signed [9:0]  CHIP_PITCH_S  = 10'(CHIP_PITCH);
    localparam logic signed [9:0]  CHIP_MAX_S    = 10'(CHIP_MAX);
    localparam logic signed [9:0]  LAYER_MAX_S   = 10'(LAYER_LOCAL_MAX);

    t_state    r_state, n_state;
    t_in_data  s_in;
    t_op       op;
    logic      accept;

    t_tbl_ctrl           tbl_ctrl;
    logic [BT_AW-1:0]    bt_addr;
    logic [CH_AW-1:0]    ch_addr;
    logic [UNIT_W-1:0]   bt_unit;
    t_ch_entry           ch_entry;
    t_ch_entry           ch_wdata;

    // request context
    logic              r_ch_ok, r_bd_ok;
    logic [1:0]        r_chip;
    logic [3:0]        r_r, r_l;
    logic [UNIT_W-1:0] r_unit;
    t_status           r_fst;
    logic [2:0]        r_blk;
    logic [6:0]        r_col;

    // scan
    logic [SC_W-1:0]   r_issue, r_pk;
    logic              r_pend;
    logic [3:0]        r_sb, r_pb, r_fb;
    logic [1:0]        r_sc, r_pc, r_fc;
    logic [6:0]        r_fch;
    logic              r_bt_found, r_ch_found;

    // result and output registers
    t_out_data         r_res, n_res;
    t_status           r_res_st, n_res_st;
    logic              res_load;
    t_out_data         r_out_data;
    t_status           r_out_st;
    logic              r_out_vld;
    logic              out_load;

    logic ch_in, bd_in;
    logic [BT_AW-1:0] fwd_bt_addr;

    assign s_in       = t_in_data'(i_s_tdata);
    assign op         = t_op'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign ch_in      = s_in.channel < NUM_CHANNELS;
    assign bd_in      = (s_in.board < NUM_BOARDS) && (s_in.connector < NUM_CONNECTORS);
    assign fwd_bt_addr = bd_in ?
        BT_AW'(int'(s_in.board) * NUM_CONNECTORS + int'(s_in.connector)) : '0;
    assign ch_wdata   = '{layer: s_in.entry_layer, row: s_in.entry_row};

    // ---------------- reverse address arithmetic ----------------
    logic        rv_range;
    logic [12:0] rv_p9;
    logic [3:0]  rv_q9, rv_col;
    logic [6:0]  rv_rem9_raw;
    logic [3:0]  rv_rem9;
    logic [2:0]  rv_blk;
    logic [6:0]  rv_u28;
    logic [1:0]  rv_q7;
    logic [2:0]  rv_rem7;
    logic        rv_mirror;
    logic [UNIT_W-1:0] rv_unit;
    logic [3:0]  rv_r, rv_l;
    logic [1:0]  rv_chip;

    always_comb begin
        rv_range = (s_in.pad_row < PAD_ROWS) && (s_in.pad_layer < PAD_LAYERS);
        // row / 9 by reciprocal 57/512, then one correction step
        rv_p9       = {6'd0, s_in.pad_row} * 13'd57;
        rv_q9       = rv_p9[12:9];
        rv_rem9_raw = s_in.pad_row - 7'(int'(rv_q9) * ROW_PITCH);
        if (rv_rem9_raw >= 7'(ROW_PITCH)) begin
            rv_col  = rv_q9 + 4'd1;
            rv_rem9 = 4'(rv_rem9_raw - 7'(ROW_PITCH));
        end else begin
            rv_col  = rv_q9;
            rv_rem9 = 4'(rv_rem9_raw);
        end
        rv_blk = '0;
        for (int k = 1; k <= 4; k++) begin
            if (int'(s_in.pad_layer) >= k * LAYER_BLOCK) rv_blk = 3'(k);
        end
        rv_u28 = s_in.pad_layer - 7'(int'(rv_blk) * LAYER_BLOCK);
        rv_q7  = '0;
        for (int k = 1; k <= 3; k++) begin
            if (int'(rv_u28) >= k * CHIP_PITCH) rv_q7 = 2'(k);
        end
        rv_rem7   = 3'(rv_u28 - 7'(int'(rv_q7) * CHIP_PITCH));
        rv_unit   = UNIT_W'(int'(rv_blk) * UNIT_BLOCK + int'(rv_col));
        rv_mirror = rv_col >= 4'(MIRROR_COL);
        if (rv_mirror) begin
            rv_r    = 4'(ROW_LOCAL_MAX) - rv_rem9;
            rv_chip = rv_q7;
            rv_l    = 4'(LAYER_LOCAL_MAX) - {1'b0, rv_rem7};
        end else begin
            rv_r    = rv_rem9;
            rv_chip = 2'(CHIP_MAX) - rv_q7;
            rv_l    = {1'b0, rv_rem7};
        end
    end

    // ---------------- forward arithmetic ----------------
    logic [2:0] f_blk;
    logic [6:0] f_col;
    t_status    f_pre;

    always_comb begin
        f_blk = '0;
        for (int k = 1; k <= 5; k++) begin
            if (int'(bt_unit) >= k * UNIT_BLOCK) f_blk = 3'(k);
        end
        f_col = 7'(int'(bt_unit) - int'(f_blk) * UNIT_BLOCK);
        if (!r_ch_ok || ch_entry.layer == LAYER_UNUSED) begin
            f_pre = ST_UNUSED;
        end else if (!r_bd_ok || bt_unit == UNIT_NONE) begin
            f_pre = ST_NOT_FOUND;
        end else begin
            f_pre = ST_OK;
        end
    end

    logic               f_mirror;
    logic signed [11:0] f_row;
    logic signed [9:0]  f_lay, f_chip_s, f_l_s;
    logic               f_fit;

    always_comb begin
        f_mirror = r_col >= 7'(MIRROR_COL);
        f_chip_s = $signed({8'd0, r_chip});
        f_l_s    = $signed({{6{r_l[3]}}, r_l});
        if (f_mirror) begin
            f_row = $signed({5'd0, r_col}) * ROW_PITCH_S + (ROW_MAX_S - $signed({8'd0, r_r}));
            f_lay = $signed({7'd0, r_blk}) * LAYER_BLK_S + f_chip_s * CHIP_PITCH_S
                    + (LAYER_MAX_S - f_l_s);
        end else begin
            f_row = $signed({5'd0, r_col}) * ROW_PITCH_S + $signed({8'd0, r_r});
            f_lay = $signed({7'd0, r_blk}) * LAYER_BLK_S
                    + (CHIP_MAX_S - f_chip_s) * CHIP_PITCH_S + f_l_s;
        end
        f_fit = (f_row >= 0) && (f_row < PAD_ROWS) && (f_lay >= 0) && (f_lay < PAD_LAYERS);
    end

    // ---------------- scan compare ----------------
    logic scan_issue, bt_hit, ch_hit, scan_last, bt_found_n, ch_found_n;

    assign scan_issue = (r_state == S_SCAN) && (r_issue < SCAN_LEN);
    assign bt_hit     = r_pend && (r_pk < BT_DEPTH) && !r_bt_found && (bt_unit == r_unit);
    assign ch_hit     = r_pend && (r_pk < NUM_CHANNELS) && !r_ch_found
                        && (ch_entry.row == r_r) && (ch_entry.layer == r_l);
    assign scan_last  = r_pend && (r_pk == SC_W'(SCAN_LEN - 1));
    assign bt_found_n = r_bt_found || bt_hit;
    assign ch_found_n = r_ch_found || ch_hit;

    // ---------------- table access ----------------
    always_comb begin
        tbl_ctrl = '0;
        bt_addr  = '0;
        ch_addr  = '0;
        if (accept) begin
            case (op)
                OP_LOAD_BOARD: begin
                    tbl_ctrl.bt_wr = bd_in;
                    bt_addr        = fwd_bt_addr;
                end
                OP_LOAD_CHANNEL: begin
                    tbl_ctrl.ch_wr = ch_in;
                    ch_addr        = CH_AW'(s_in.channel);
                end
                OP_FORWARD: begin
                    tbl_ctrl.bt_rd = 1'b1;
                    tbl_ctrl.ch_rd = 1'b1;
                    bt_addr        = fwd_bt_addr;
                    ch_addr        = ch_in ? CH_AW'(s_in.channel) : '0;
                end
                default: begin
                end
            endcase
        end else if (scan_issue) begin
            tbl_ctrl.bt_rd = r_issue < BT_DEPTH;
            tbl_ctrl.ch_rd = r_issue < NUM_CHANNELS;
            bt_addr        = r_issue[BT_AW-1:0];
            ch_addr        = r_issue[CH_AW-1:0];
        end
    end

    rcpm_tables #(.BT_DEPTH(BT_DEPTH), .CH_DEPTH(NUM_CHANNELS)) u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (tbl_ctrl),
        .i_bt_addr  (bt_addr),
        .i_bt_wdata (s_in.unit_index),
        .i_ch_addr  (ch_addr),
        .i_ch_wdata (ch_wdata),
        .o_bt_unit  (bt_unit),
        .o_ch_entry (ch_entry)
    );

    // ---------------- sequencer and result ----------------
    assign out_load = (r_state == S_DONE) && (!r_out_vld || i_m_tready);

    always_comb begin
        n_state  = r_state;
        n_res    = '0;
        n_res_st = ST_OK;
        res_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_FORWARD: n_state = S_READ;
                        OP_REVERSE: begin
                            if (rv_range) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state  = S_DONE;
                                res_load = 1'b1;
                                n_res_st = ST_RANGE;
                            end
                        end
                        default: begin
                            n_state  = S_DONE;
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: n_state = S_FWD;
            S_FWD: begin
                n_state  = S_DONE;
                res_load = 1'b1;
                if (r_fst != ST_OK) begin
                    n_res_st = r_fst;
                end else if (!f_fit) begin
                    n_res_st = ST_RANGE;
                end else begin
                    n_res.out_pad_row   = f_row[6:0];
                    n_res.out_pad_layer = f_lay[6:0];
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state        = S_DONE;
                    res_load       = 1'b1;
                    n_res.out_unit = r_unit;
                    n_res.out_chip = r_chip;
                    if (bt_found_n && ch_found_n) begin
                        n_res.out_board     = bt_hit ? r_pb : r_fb;
                        n_res.out_connector = bt_hit ? r_pc : r_fc;
                        n_res.out_channel   = ch_hit ? 7'(r_pk) : r_fch;
                    end else begin
                        n_res_st = ST_NOT_FOUND;
                    end
                end
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= scan_issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch_ok    <= ch_in;
            r_bd_ok    <= bd_in;
            r_chip     <= (op == OP_FORWARD) ? s_in.chip : rv_chip;
            r_r        <= rv_r;
            r_l        <= rv_l;
            r_unit     <= rv_unit;
            r_issue    <= '0;
            r_sb       <= '0;
            r_sc       <= '0;
            r_bt_found <= 1'b0;
            r_ch_found <= 1'b0;
        end
        if (r_state == S_READ) begin
            r_fst <= f_pre;
            r_blk <= f_blk;
            r_col <= f_col;
            r_l   <= ch_entry.layer;
            r_r   <= ch_entry.row;
        end
        if (scan_issue) begin
            r_issue <= r_issue + 1'b1;
            r_pk    <= r_issue;
            r_pb    <= r_sb;
            r_pc    <= r_sc;
            if (r_sc == 2'(NUM_CONNECTORS - 1)) begin
                r_sc <= '0;
                r_sb <= r_sb + 4'd1;
            end else begin
                r_sc <= r_sc + 2'd1;
            end
        end
        if (r_state == S_SCAN) begin
            r_bt_found <= bt_found_n;
            r_ch_found <= ch_found_n;
            if (bt_hit) begin
                r_fb <= r_pb;
                r_fc <= r_pc;
            end
            if (ch_hit) begin
                r_fch <= 7'(r_pk);
            end
        end
        if (res_load) begin
            r_res    <= n_res;
            r_res_st <= n_res_st;
        end
        if (out_load) begin
            r_out_data <= r_res;
            r_out_st   <= r_res_st;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_st;

    // ---------------- assertions ----------------
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_ctrl.bt_wr || tbl_ctrl.ch_wr) |-> accept)
        else $error("table write without an accepted request");

    a_no_rd_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_ctrl.bt_rd && tbl_ctrl.bt_wr) && !(tbl_ctrl.ch_rd && tbl_ctrl.ch_wr))
        else $error("table read and write in the same cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("ready held after accepting a request");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_last) |=> (r_state == S_DONE))
        else $error("scan did not finish after its last entry");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

endmodule
`default_nettype wire

/* tb/readout_channel_pad_mapper_tb.sv */
// ----------------------------------------------------------------------------
// readout_channel_pad_mapper_tb
// Self-checking bench for the pad mapper. Requests go through a stream
// source with random gaps, and results are taken by a sink with random
// stalls. A local model of the board and channel tables predicts each
// result, which is checked field by field in arrival order. Directed tests
// cover empty tables, ignored loads, mirrored and plain forward mapping,
// overflow and reverse lookups. Random rounds then refill the tables and
// mix forward, reverse, load and junk requests.
// ----------------------------------------------------------------------------
module readout_channel_pad_mapper_tb;
    import rcpm_pkg::*;

    localparam int NB            = NUM_BOARDS_DEF;
    localparam int NC            = NUM_CONNECTORS_DEF;
    localparam int NCH           = NUM_CHANNELS_DEF;
    localparam int PR            = PAD_ROWS_DEF;
    localparam int PL            = PAD_LAYERS_DEF;
    localparam int BT_DEPTH      = NB * NC;
    localparam int IDLE_LIMIT    = 2000;   // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 100;    // longer than the slowest reverse scan
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        t_op      op;
        t_in_data data;
    } t_request;

    typedef struct {
        t_status   status;
        t_out_data data;
    } t_mapping;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [USER_W-1:0]     s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [USER_W-1:0]     m_tuser;

    // local copy of the mapping tables
    logic [UNIT_W-1:0]     board_units [BT_DEPTH];
    logic signed [3:0]     chan_layer  [NCH];
    logic [3:0]            chan_row    [NCH];

    t_request              request_q [$];
    t_mapping              mapping_q [$];

    int src_gap_max = 12;
    int snk_gap_max = 12;
    int n_errors    = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_per_op     [4];
    int n_per_status [4];
    int idle_cycles = 0;

    always #5 clk = ~clk;

    readout_channel_pad_mapper uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    task automatic clear_tables();
        for (int i = 0; i < BT_DEPTH; i++) board_units[i] = UNIT_NONE;
        for (int i = 0; i < NCH; i++) begin
            chan_layer[i] = LAYER_UNUSED;
            chan_row[i]   = 4'd0;
        end
    endtask

    // Applies one request to the local tables and returns the mapping it gives.
    function automatic t_mapping map_request(input t_op op, input t_in_data d);
        t_mapping res;
        int unit, col, blk, row, lay, rw, lyr, chip, in_blk, bt_hit, ch_hit;
        res.status = ST_OK;
        res.data   = '0;
        case (op)
            OP_LOAD_BOARD: begin
                if (d.board < NB && d.connector < NC)
                    board_units[d.board * NC + d.connector] = d.unit_index;
            end
            OP_LOAD_CHANNEL: begin
                if (d.channel < NCH) begin
                    chan_layer[d.channel] = d.entry_layer;
                    chan_row[d.channel]   = d.entry_row;
                end
            end
            OP_FORWARD: begin
                // unused channel wins over a missing board
                if (d.channel >= NCH) begin
                    res.status = ST_UNUSED;
                end else if (chan_layer[d.channel] == LAYER_UNUSED) begin
                    res.status = ST_UNUSED;
                end else if (d.board >= NB || d.connector >= NC) begin
                    res.status = ST_NOT_FOUND;
                end else if (board_units[d.board * NC + d.connector] == UNIT_NONE) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    unit = int'(board_units[d.board * NC + d.connector]);
                    lyr  = int'(chan_layer[d.channel]);
                    rw   = int'(chan_row[d.channel]);
                    chip = int'(d.chip);
                    col  = unit % UNIT_BLOCK;
                    blk  = unit / UNIT_BLOCK;
                    if (col < MIRROR_COL) begin
                        row = col * ROW_PITCH + rw;
                        lay = blk * LAYER_BLOCK + (CHIP_MAX - chip) * CHIP_PITCH + lyr;
                    end else begin
                        row = col * ROW_PITCH + (ROW_LOCAL_MAX - rw);
                        lay = blk * LAYER_BLOCK + chip * CHIP_PITCH + (LAYER_LOCAL_MAX - lyr);
                    end
                    if (row < 0 || row >= PR || lay < 0 || lay >= PL) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.data.out_pad_row   = 7'(row);
                        res.data.out_pad_layer = 7'(lay);
                    end
                end
            end
            OP_REVERSE: begin
                row = int'(d.pad_row);
                lay = int'(d.pad_layer);
                if (row >= PR || lay >= PL) begin
                    res.status = ST_RANGE;
                end else begin
                    col    = row / ROW_PITCH;
                    blk    = lay / LAYER_BLOCK;
                    unit   = blk * UNIT_BLOCK + col;
                    in_blk = lay % LAYER_BLOCK;
                    if (col < MIRROR_COL) begin
                        rw   = row % ROW_PITCH;
                        chip = CHIP_MAX - in_blk / CHIP_PITCH;
                        lyr  = in_blk % CHIP_PITCH;
                    end else begin
                        rw   = ROW_LOCAL_MAX - row % ROW_PITCH;
                        chip = in_blk / CHIP_PITCH;
                        lyr  = LAYER_LOCAL_MAX - in_blk % CHIP_PITCH;
                    end
                    res.data.out_unit = 9'(unit);
                    res.data.out_chip = 2'(chip);
                    // lowest matching entry of each table
                    bt_hit = -1;
                    ch_hit = -1;
                    for (int i = 0; i < BT_DEPTH && bt_hit < 0; i++)
                        if (int'(board_units[i]) == unit) bt_hit = i;
                    for (int i = 0; i < NCH && ch_hit < 0; i++)
                        if (int'(chan_row[i]) == rw && int'(chan_layer[i]) == lyr) ch_hit = i;
                    if (bt_hit < 0 || ch_hit < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.data.out_board     = 4'(bt_hit / NC);
                        res.data.out_connector = 2'(bt_hit % NC);
                        res.data.out_channel   = 7'(ch_hit);
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // request source: gap, then drive the next queued request until taken
    always @(posedge clk) begin : source
        int gap_left;
        t_request req;
        t_mapping want;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = $urandom_range(0, src_gap_max);
        end else begin
            if (s_tvalid && s_tready) begin
                want = map_request(t_op'(s_tuser), t_in_data'(s_tdata));
                mapping_q.push_back(want);
                n_requests++;
                n_per_op[s_tuser]++;
                n_per_status[want.status]++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || request_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.data;
                    s_tuser  <= req.op;
                    gap_left = $urandom_range(0, src_gap_max);
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (n_errors < MAX_PRINTS)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_result();
        t_mapping  want;
        t_out_data got;
        if (mapping_q.size() == 0) begin
            report_mismatch("result with nothing pending", 16'(m_tuser), 16'd0);
        end else begin
            want = mapping_q.pop_front();
            got  = m_tdata;
            n_results++;
            check_field("status",        16'(m_tuser),           16'(want.status));
            check_field("out_pad_row",   16'(got.out_pad_row),   16'(want.data.out_pad_row));
            check_field("out_pad_layer", 16'(got.out_pad_layer),
                        16'(want.data.out_pad_layer));
            check_field("out_unit",      16'(got.out_unit),      16'(want.data.out_unit));
            check_field("out_board",     16'(got.out_board),     16'(want.data.out_board));
            check_field("out_connector", 16'(got.out_connector),
                        16'(want.data.out_connector));
            check_field("out_chip",      16'(got.out_chip),      16'(want.data.out_chip));
            check_field("out_channel",   16'(got.out_channel),   16'(want.data.out_channel));
            check_field("tdata pad",     16'(got.pad),           16'(want.data.pad));
        end
    endtask

    // result sink with random stalls after each result
    always @(posedge clk) begin : sink
        int stall_left;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tready && m_tvalid) begin
                check_result();
                stall_left = $urandom_range(0, snk_gap_max);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input t_op op, input t_in_data d);
        t_request req;
        req.op   = op;
        req.data = d;
        request_q.push_back(req);
        while (request_q.size() > 1) @(posedge clk);
    endtask

    // holds further requests until every pending result has come back;
    // sampled on the falling edge so the source has settled
    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || mapping_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic t_in_data random_fields();
        t_in_data d;
        d             = t_in_data'(48'({$urandom, $urandom}));
        d.pad         = '0;
        d.unit_index  = 9'($urandom_range(0, 311));
        d.entry_layer = 4'($urandom_range(0, 8) - 2);
        d.entry_row   = 4'($urandom_range(0, 8));
        return d;
    endfunction

    task automatic load_board(input int board, input int conn, input int unit);
        t_in_data d;
        d            = random_fields();
        d.board      = 4'(board);
        d.connector  = 2'(conn);
        d.unit_index = 9'(unit);
        send_request(OP_LOAD_BOARD, d);
    endtask

    task automatic load_channel(input int chan, input int lyr, input int rw);
        t_in_data d;
        d             = random_fields();
        d.channel     = 7'(chan);
        d.entry_layer = 4'(lyr);
        d.entry_row   = 4'(rw);
        send_request(OP_LOAD_CHANNEL, d);
    endtask

    task automatic forward(input int board, input int conn, input int chip, input int chan);
        t_in_data d;
        d           = random_fields();
        d.board     = 4'(board);
        d.connector = 2'(conn);
        d.chip      = 2'(chip);
        d.channel   = 7'(chan);
        send_request(OP_FORWARD, d);
    endtask

    task automatic reverse(input int prow, input int play);
        t_in_data d;
        d           = random_fields();
        d.pad_row   = 7'(prow);
        d.pad_layer = 7'(play);
        send_request(OP_REVERSE, d);
    endtask

    task automatic test_empty_tables();
        reverse(0, 0);
        forward(0, 0, 0, 0);
        forward(15, 3, 3, 127);
    endtask

    task automatic test_table_loads();
        load_board(0, 0, 0);
        load_board(NB - 1, NC - 1, 311);
        load_board(NB, 0, 5);           // board out of range, dropped
        load_board(15, 3, 5);
        load_channel(0, 0, 0);
        load_channel(NCH - 1, LAYER_LOCAL_MAX, ROW_LOCAL_MAX);
        load_channel(NCH, 3, 3);        // channel out of range, dropped
        load_channel(127, 3, 3);
    endtask

    task automatic test_forward_map();
        forward(0, 0, 0, 0);
        forward(NB - 1, NC - 1, CHIP_MAX, NCH - 1);   // mirrored column
        forward(1, 0, 2, 0);                          // board entry never set
        forward(13, 1, 1, 0);
        forward(NB, 0, 1, NCH);                       // unused checked first
    endtask

    task automatic test_forward_overflow();
        load_board(2, 1, 99);
        forward(2, 1, 0, 0);            // row far past the pad plane
        load_channel(1, -1, 0);
        forward(0, 0, CHIP_MAX, 1);     // layer below zero
        load_channel(2, -2, 8);
        forward(0, 0, 0, 2);
    endtask

    task automatic test_reverse_map();
        reverse(0, 21);
        reverse(99, 105);
        reverse(PR - 1, PL - 1);
        reverse(PR, 0);
        reverse(0, PL);
        reverse(127, 127);
    endtask

    task automatic test_random_traffic(input int rounds, input int mixed_per_round);
        t_in_data d;
        int pick;
        for (int r = 0; r < rounds; r++) begin
            case (r % 4)
                0:       begin src_gap_max = 0;  snk_gap_max = 0;  end
                1:       begin src_gap_max = 12; snk_gap_max = 12; end
                2:       begin src_gap_max = 0;  snk_gap_max = 12; end
                default: begin src_gap_max = 12; snk_gap_max = 0;  end
            endcase
            // refill with plausible geometry so that lookups mostly hit
            for (int i = 0; i < BT_DEPTH; i++)
                load_board(i / NC, i % NC,
                           $urandom_range(0, 3) * UNIT_BLOCK + $urandom_range(0, 11));
            for (int i = 0; i < NCH; i++)
                load_channel(i, ($urandom_range(0, 9) == 0) ? -2
                                : $urandom_range(0, LAYER_LOCAL_MAX),
                             $urandom_range(0, ROW_LOCAL_MAX));
            for (int n = 0; n < mixed_per_round; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    forward($urandom_range(0, NB - 1), $urandom_range(0, NC - 1),
                            $urandom_range(0, CHIP_MAX), $urandom_range(0, NCH - 1));
                end else if (pick < 85) begin
                    reverse($urandom_range(0, PR - 1), $urandom_range(0, PL - 1));
                end else if (pick < 89) begin
                    load_board($urandom_range(0, NB - 1), $urandom_range(0, NC - 1),
                               $urandom_range(0, 3) * UNIT_BLOCK + $urandom_range(0, 11));
                end else if (pick < 93) begin
                    load_channel($urandom_range(0, NCH - 1),
                                 $urandom_range(0, LAYER_LOCAL_MAX),
                                 $urandom_range(0, ROW_LOCAL_MAX));
                end else begin
                    d = random_fields();
                    send_request(t_op'($urandom_range(0, 3)), d);
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        clear_tables();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_tables();
        wait_idle();
        test_table_loads();
        test_forward_map();
        wait_idle();
        test_forward_overflow();
        test_reverse_map();
        wait_idle();
        test_random_traffic(4, 290);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("requests: %0d (board loads %0d, channel loads %0d, forward %0d, reverse %0d)",
                 n_requests, n_per_op[OP_LOAD_BOARD], n_per_op[OP_LOAD_CHANNEL],
                 n_per_op[OP_FORWARD], n_per_op[OP_REVERSE]);
        $display("results checked: %0d (ok %0d, unused %0d, range %0d, not found %0d)",
                 n_results, n_per_status[ST_OK], n_per_status[ST_UNUSED],
                 n_per_status[ST_RANGE], n_per_status[ST_NOT_FOUND]);
        if (n_errors == 0 && mapping_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
